>>> design/pcbd_pkg.sv
// Package for the pulse-count backlight dimmer: operation codes, register
// indexes, fixed field widths, reset values and the status struct.
// No dependencies.
package pcbd_pkg;

    // Operation codes of an input item
    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_POWER_ON  = 2'd1;
    localparam logic [1:0] OP_POWER_OFF = 2'd2;
    localparam logic [1:0] OP_SET_LEVEL = 2'd3;

    // Configuration port
    localparam int         CFG_IDX_W       = 2;
    localparam int         CFG_DATA_W      = 16;
    localparam logic [1:0] CFG_MAX_LEVEL   = 2'd0;
    localparam logic [1:0] CFG_HALF_PERIOD = 2'd1;

    // Fixed field widths
    localparam int OP_W        = 2;
    localparam int PCT_W       = 8;
    localparam int MAX_LEVEL_W = 6;
    localparam int HALF_W      = 16;

    // Percent saturation
    localparam int                 PCT_SAT_W = 7;
    localparam logic [PCT_SAT_W-1:0] PCT_FULL = 7'd100;

    // x / 100 == (x * 5243) >> 19, exact for x below 43690
    localparam int                RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_MUL  = 13'd5243;
    localparam int                RECIP_SHIFT = 19;

    // Reset values
    localparam int RESET_MAX_LEVEL = 32;
    localparam int RESET_HALF      = 10;

    // Status of one result item
    typedef struct packed {
        logic pin;
        logic busy;
        logic rejected;
    } t_status;

endpackage

>>> design/pcbd_if.sv
// Handshake interfaces of the pulse-count backlight dimmer: command items,
// result items and configuration writes. Depends on pcbd_pkg.
interface pcbd_in_if;
    logic                          valid;
    logic                          ready;
    logic [pcbd_pkg::OP_W-1:0]     operation;
    logic [pcbd_pkg::PCT_W-1:0]    level_percent;

    modport source (output valid, output operation, output level_percent, input ready);
    modport sink   (input valid, input operation, input level_percent, output ready);
endinterface

interface pcbd_out_if #(
    parameter int LEVEL_BITS = 6
);
    logic                  valid;
    logic                  ready;
    logic                  pin_state;
    logic                  busy_res;
    logic [LEVEL_BITS-1:0] current_level;
    logic                  rejected;

    modport source (output valid, output pin_state, output busy_res, output current_level,
                    output rejected, input ready);
    modport sink   (input valid, input pin_state, input busy_res, input current_level,
                    input rejected, output ready);
endinterface

interface pcbd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pcbd_pkg::CFG_IDX_W-1:0]     index;
    logic [pcbd_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/pulse_count_backlight_dimmer.sv
// Pulse-count backlight dimmer. Each command item (tick, power on, power off,
// set level) produces exactly one result item carrying the control pin, the
// busy flag, the committed level and a rejected flag. Throughput is one item
// per clock while results are taken; a held result can stall the input. An item
// waits in the input register, the state update (level mapping multiply plus
// pulse counters) works on it combinationally, and its result is registered
// in the output register. The output register lets a new item be taken while
// a result waits. Configuration writes are taken every cycle and apply in the
// next cycle. Depends on pcbd_pkg, the interfaces in pcbd_if and pcbd_core.
module pulse_count_backlight_dimmer #(
    parameter int LEVEL_BITS = 6,
    parameter int TICK_BITS  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcbd_cfg_if.sink   i_cfg,
    pcbd_in_if.sink    i_in,
    pcbd_out_if.source o_out
);

    localparam int RW = LEVEL_BITS + pcbd_pkg::RECIP_W;
    localparam logic [LEVEL_BITS-1:0] RESET_MAX_RAW =
        LEVEL_BITS'(pcbd_pkg::RESET_MAX_LEVEL);
    localparam logic [LEVEL_BITS-1:0] RESET_EFF_MAX =
        (RESET_MAX_RAW == '0) ? LEVEL_BITS'(1) : RESET_MAX_RAW;
    localparam logic [RW-1:0] RESET_RECIP = RW'(RESET_EFF_MAX) * RW'(pcbd_pkg::RECIP_MUL);
    localparam logic [TICK_BITS-1:0] RESET_HALF = TICK_BITS'(pcbd_pkg::RESET_HALF);

    // configuration registers, held in effective form (zero reads as one)
    logic [LEVEL_BITS-1:0] r_eff_max;
    logic [RW-1:0]         r_max_recip;
    logic [TICK_BITS-1:0]  r_eff_half;
    logic [LEVEL_BITS-1:0] s_cfg_max;
    logic [LEVEL_BITS-1:0] s_cfg_eff_max;
    logic [TICK_BITS-1:0]  s_cfg_half;

    // input and output registers
    logic                          r_in_valid;
    logic [pcbd_pkg::OP_W-1:0]     r_in_op;
    logic [pcbd_pkg::PCT_W-1:0]    r_in_pct;
    logic                          r_out_valid;
    pcbd_pkg::t_status             r_out_status;
    logic [LEVEL_BITS-1:0]         r_out_level;

    logic                  s_go;
    pcbd_pkg::t_status     s_status;
    logic [LEVEL_BITS-1:0] s_level;

    // configuration write decode
    assign i_cfg.ready   = 1'b1;
    assign s_cfg_max     = LEVEL_BITS'(i_cfg.data[pcbd_pkg::MAX_LEVEL_W-1:0]);
    assign s_cfg_eff_max = (s_cfg_max == '0) ? LEVEL_BITS'(1) : s_cfg_max;
    assign s_cfg_half    = TICK_BITS'(i_cfg.data[pcbd_pkg::HALF_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_max   <= RESET_EFF_MAX;
            r_max_recip <= RESET_RECIP;
            r_eff_half  <= RESET_HALF;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                pcbd_pkg::CFG_MAX_LEVEL: begin
                    r_eff_max   <= s_cfg_eff_max;
                    r_max_recip <= RW'(s_cfg_eff_max) * RW'(pcbd_pkg::RECIP_MUL);
                end
                pcbd_pkg::CFG_HALF_PERIOD: begin
                    r_eff_half <= (s_cfg_half == '0) ? TICK_BITS'(1) : s_cfg_half;
                end
                default: begin
                end
            endcase
        end
    end

    // the item in the input register moves on when the result slot is free
    assign s_go       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || s_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_op  <= i_in.operation;
            r_in_pct <= i_in.level_percent;
        end
    end

    pcbd_core #(
        .LEVEL_BITS (LEVEL_BITS),
        .TICK_BITS  (TICK_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (s_go),
        .i_op        (r_in_op),
        .i_pct       (r_in_pct),
        .i_eff_max   (r_eff_max),
        .i_max_recip (r_max_recip),
        .i_eff_half  (r_eff_half),
        .o_status    (s_status),
        .o_level     (s_level)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_go) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_go) begin
            r_out_status <= s_status;
            r_out_level  <= s_level;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.pin_state     = r_out_status.pin;
    assign o_out.busy_res      = r_out_status.busy;
    assign o_out.current_level = r_out_level;
    assign o_out.rejected      = r_out_status.rejected;

    // a rejected command leaves the pulse train running
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status.rejected |-> r_out_status.busy)
        else $error("rejected result without a running pulse train");

    // a rejected command does not move the committed level
    a_reject_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_go && s_status.rejected |=> r_out_level == $past(r_out_level))
        else $error("rejected command changed the level");

    // input stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_in_valid && r_out_valid && !o_out.ready)
        else $error("input stalled without a waiting result");

endmodule

>>> design/pcbd_level_map.sv
// Percent to level mapping: saturate to 100, scale by the step count,
// divide by 100 through a reciprocal multiply, clip to 1..max. Uses pcbd_pkg.
module pcbd_level_map #(
    parameter int LEVEL_BITS = 6
) (
    input  logic [pcbd_pkg::PCT_W-1:0]             i_pct,
    input  logic [LEVEL_BITS-1:0]                  i_eff_max,
    input  logic [LEVEL_BITS+pcbd_pkg::RECIP_W-1:0] i_max_recip,
    output logic [LEVEL_BITS-1:0]                  o_level
);

    localparam int RW = LEVEL_BITS + pcbd_pkg::RECIP_W;
    localparam int PW = pcbd_pkg::PCT_SAT_W + RW;

    logic [pcbd_pkg::PCT_SAT_W-1:0] s_pct_sat;
    logic [PW-1:0]                  s_prod;
    logic [LEVEL_BITS-1:0]          s_raw;

    // saturate, then pct * max * 5243 >> 19 (max*5243 is precomputed)
    assign s_pct_sat = (i_pct > pcbd_pkg::PCT_W'(pcbd_pkg::PCT_FULL))
                       ? pcbd_pkg::PCT_FULL : i_pct[pcbd_pkg::PCT_SAT_W-1:0];
    assign s_prod    = PW'(s_pct_sat) * PW'(i_max_recip);
    assign s_raw     = s_prod[pcbd_pkg::RECIP_SHIFT +: LEVEL_BITS];

    // clip into 1..max
    always_comb begin
        if (s_raw > i_eff_max) begin
            o_level = i_eff_max;
        end else if (s_raw == '0) begin
            o_level = LEVEL_BITS'(1);
        end else begin
            o_level = s_raw;
        end
    end

endmodule

>>> design/pcbd_core.sv
// Dimmer state and per-item update: pin, committed level, pulse train
// counters. Depends on pcbd_pkg and pcbd_level_map.
module pcbd_core #(
    parameter int LEVEL_BITS = 6,
    parameter int TICK_BITS  = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_go,
    input  logic [pcbd_pkg::OP_W-1:0]              i_op,
    input  logic [pcbd_pkg::PCT_W-1:0]             i_pct,
    input  logic [LEVEL_BITS-1:0]                  i_eff_max,
    input  logic [LEVEL_BITS+pcbd_pkg::RECIP_W-1:0] i_max_recip,
    input  logic [TICK_BITS-1:0]                   i_eff_half,
    output pcbd_pkg::t_status                      o_status,
    output logic [LEVEL_BITS-1:0]                  o_level
);

    localparam logic [LEVEL_BITS-1:0] RESET_LEVEL = LEVEL_BITS'(pcbd_pkg::RESET_MAX_LEVEL);

    logic                  r_pin, n_pin;
    logic [LEVEL_BITS-1:0] r_level, n_level;
    logic [LEVEL_BITS-1:0] r_pulses, n_pulses;
    logic [TICK_BITS-1:0]  r_half_cnt, n_half_cnt;
    logic                  r_low_half, n_low_half;
    logic                  s_rej;
    logic                  s_busy;
    logic [TICK_BITS-1:0]  s_half_dec;
    logic [LEVEL_BITS-1:0] s_pulses_dec;
    logic [LEVEL_BITS-1:0] s_map_level;
    logic [LEVEL_BITS-1:0] s_cnt;

    pcbd_level_map #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_level_map (
        .i_pct       (i_pct),
        .i_eff_max   (i_eff_max),
        .i_max_recip (i_max_recip),
        .o_level     (s_map_level)
    );

    assign s_busy       = (r_pulses != '0);
    assign s_half_dec   = (r_half_cnt != '0) ? r_half_cnt - TICK_BITS'(1) : '0;
    assign s_pulses_dec = r_pulses - LEVEL_BITS'(1);
    // pulses wrap downward: a rise costs max minus the rise
    assign s_cnt = (s_map_level > r_level) ? i_eff_max - (s_map_level - r_level)
                                           : r_level - s_map_level;

    // next state for the item in hand
    always_comb begin
        n_pin      = r_pin;
        n_level    = r_level;
        n_pulses   = r_pulses;
        n_half_cnt = r_half_cnt;
        n_low_half = r_low_half;
        s_rej      = 1'b0;
        if (i_op == pcbd_pkg::OP_TICK) begin
            if (s_busy) begin
                if (s_half_dec != '0) begin
                    n_half_cnt = s_half_dec;
                end else if (!r_low_half) begin
                    n_pin      = 1'b0;
                    n_low_half = 1'b1;
                    n_half_cnt = i_eff_half;
                end else begin
                    n_pulses   = s_pulses_dec;
                    n_pin      = 1'b1;
                    n_low_half = 1'b0;
                    n_half_cnt = (s_pulses_dec != '0) ? i_eff_half : s_half_dec;
                end
            end
        end else if (s_busy) begin
            s_rej = 1'b1;
        end else begin
            case (i_op)
                pcbd_pkg::OP_POWER_ON: begin
                    n_pin   = 1'b1;
                    n_level = i_eff_max;
                end
                pcbd_pkg::OP_POWER_OFF: begin
                    n_pin = 1'b0;
                end
                pcbd_pkg::OP_SET_LEVEL: begin
                    n_pin = 1'b1;
                    if (s_map_level != r_level && s_cnt != '0) begin
                        n_pulses   = s_cnt;
                        n_half_cnt = i_eff_half;
                        n_low_half = 1'b0;
                    end
                    n_level = s_map_level;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_status.pin      = n_pin;
    assign o_status.busy     = (n_pulses != '0);
    assign o_status.rejected = s_rej;
    assign o_level           = n_level;

    // state registers, advanced once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin      <= 1'b0;
            r_level    <= RESET_LEVEL;
            r_pulses   <= '0;
            r_half_cnt <= '0;
            r_low_half <= 1'b0;
        end else if (i_go) begin
            r_pin      <= n_pin;
            r_level    <= n_level;
            r_pulses   <= n_pulses;
            r_half_cnt <= n_half_cnt;
            r_low_half <= n_low_half;
        end
    end

endmodule

>>> dv/tb_pulse_count_backlight_dimmer.sv
`timescale 1ns / 1ps
// Self-checking testbench for pulse_count_backlight_dimmer: a directed table, then random
// command phases under several register settings, checked against an in-bench predictor.
// Depends on pcbd_pkg, the pcbd_if interfaces and the dimmer RTL.
module tb_pulse_count_backlight_dimmer;

    localparam int LVL_W       = 6;
    localparam int TCK_W       = 16;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int PIPE_CYCLES = 4;     // pipeline drain margin
    localparam int PHASE_ITEMS = 150;
    localparam int NUM_PHASES  = 6;
    localparam int MAX_REPORTS = 10;

    // Register indexes the block does not decode
    localparam logic [pcbd_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [pcbd_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic             pin;
        logic             busy;
        logic [LVL_W-1:0] level;
        logic             rej;
    } t_dim_res;

    typedef enum logic [1:0] {ROW_ITEM, ROW_CFG, ROW_DRAIN} t_row_kind;

    typedef struct {
        t_row_kind                       kind;
        logic [pcbd_pkg::OP_W-1:0]       op;
        logic [pcbd_pkg::PCT_W-1:0]      pct;
        t_dim_res                        res;
        logic [pcbd_pkg::CFG_IDX_W-1:0]  idx;
        logic [pcbd_pkg::CFG_DATA_W-1:0] data;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pcbd_cfg_if                       cfg_bus();
    pcbd_in_if                        cmd_bus();
    pcbd_out_if #(.LEVEL_BITS(LVL_W)) res_bus();

    pulse_count_backlight_dimmer #(
        .LEVEL_BITS(LVL_W),
        .TICK_BITS (TCK_W)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_bus),
        .i_in   (cmd_bus),
        .o_out  (res_bus)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor copy of registers and pulse-train state
    logic [LVL_W-1:0] max_reg;
    logic [TCK_W-1:0] half_reg;
    logic             pin_st;
    logic [LVL_W-1:0] level_st;
    logic [LVL_W-1:0] pulses_st;
    logic [TCK_W-1:0] half_cnt_st;
    logic             low_half_st;

    t_dim_res pending_status[$];
    int       fails      = 0;
    int       cycles     = 0;
    int       burst_left = 0;

    // Receiver stall state
    int        hold_asked = 0;
    int        hold_seen  = 0;
    int        hold_left  = 0;
    int        pat_age    = 0;
    logic [7:0] stall_pat = 8'hFF;
    logic [2:0] pat_pos   = 3'd0;

    function automatic logic [TCK_W-1:0] half_eff();
        return (half_reg == '0) ? TCK_W'(1) : half_reg;
    endfunction

    // One command item against the predictor state; returns the status it should produce
    function automatic t_dim_res dimmer_step(input logic [pcbd_pkg::OP_W-1:0] op,
                                             input logic [pcbd_pkg::PCT_W-1:0] pct);
        int unsigned m;
        int unsigned p;
        int unsigned lv;
        int unsigned cnt;
        t_dim_res    r;
        m     = (max_reg == '0) ? 1 : max_reg;
        r.rej = 1'b0;
        if (op == pcbd_pkg::OP_TICK) begin
            // ticks only matter while a train runs
            if (pulses_st != '0) begin
                if (half_cnt_st != '0) half_cnt_st = half_cnt_st - 1'b1;
                if (half_cnt_st == '0) begin
                    if (!low_half_st) begin
                        pin_st      = 1'b0;
                        low_half_st = 1'b1;
                        half_cnt_st = half_eff();
                    end else begin
                        pulses_st   = pulses_st - 1'b1;
                        pin_st      = 1'b1;
                        low_half_st = 1'b0;
                        if (pulses_st != '0) half_cnt_st = half_eff();
                    end
                end
            end
        end else if (pulses_st != '0) begin
            r.rej = 1'b1;
        end else if (op == pcbd_pkg::OP_POWER_ON) begin
            pin_st   = 1'b1;
            level_st = LVL_W'(m);
        end else if (op == pcbd_pkg::OP_POWER_OFF) begin
            pin_st = 1'b0;
        end else begin
            // percent -> level in 1..max, then count pulses with downward wrap
            p  = (pct > 100) ? 100 : pct;
            lv = p * m / 100;
            if (lv < 1) lv = 1;
            if (lv != level_st) begin
                cnt       = (lv > level_st) ? m - (lv - level_st) : level_st - lv;
                pulses_st = LVL_W'(cnt);
                if (pulses_st != '0) begin
                    half_cnt_st = half_eff();
                    low_half_st = 1'b0;
                end
            end
            pin_st   = 1'b1;
            level_st = LVL_W'(lv);
        end
        r.pin   = pin_st;
        r.busy  = (pulses_st != '0);
        r.level = level_st;
        return r;
    endfunction

    task automatic log_fail(input string what);
        fails++;
        if (fails <= MAX_REPORTS) $display("%0t: %s", $realtime, what);
    endtask

    // Offer one command item in bursts with random gaps; predict on acceptance
    task automatic send_cmd(input logic [pcbd_pkg::OP_W-1:0] op,
                            input logic [pcbd_pkg::PCT_W-1:0] pct,
                            input bit typed, input t_dim_res typed_res);
        int       gap;
        t_dim_res r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            repeat (gap) begin
                @(negedge i_clk);
                cmd_bus.valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        cmd_bus.valid         <= 1'b1;
        cmd_bus.operation     <= op;
        cmd_bus.level_percent <= pct;
        do @(posedge i_clk); while (!cmd_bus.ready);
        r = dimmer_step(op, pct);
        pending_status.push_back(typed ? typed_res : r);
    endtask

    task automatic stop_cmd();
        @(negedge i_clk);
        cmd_bus.valid <= 1'b0;
    endtask

    // Register write, only once the pipeline has drained
    task automatic write_reg(input logic [pcbd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pcbd_pkg::CFG_DATA_W-1:0] data);
        stop_cmd();
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (PIPE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        if (idx == pcbd_pkg::CFG_MAX_LEVEL) max_reg = data[LVL_W-1:0];
        else if (idx == pcbd_pkg::CFG_HALF_PERIOD) half_reg = data[TCK_W-1:0];
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic t_plan_row cmd_row(input logic [pcbd_pkg::OP_W-1:0] op,
                                          input logic [pcbd_pkg::PCT_W-1:0] pct,
                                          input logic pin, input logic busy,
                                          input logic [LVL_W-1:0] lvl, input logic rej);
        t_plan_row row;
        row.kind = ROW_ITEM;
        row.op   = op;
        row.pct  = pct;
        row.res  = t_dim_res'{pin, busy, lvl, rej};
        row.idx  = '0;
        row.data = '0;
        return row;
    endfunction

    function automatic t_plan_row reg_row(input logic [pcbd_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [pcbd_pkg::CFG_DATA_W-1:0] data);
        t_plan_row row;
        row      = cmd_row(pcbd_pkg::OP_TICK, '0, 1'b0, 1'b0, '0, 1'b0);
        row.kind = ROW_CFG;
        row.idx  = idx;
        row.data = data;
        return row;
    endfunction

    function automatic t_plan_row drain_row();
        t_plan_row row;
        row      = cmd_row(pcbd_pkg::OP_TICK, '0, 1'b0, 1'b0, '0, 1'b0);
        row.kind = ROW_DRAIN;
        return row;
    endfunction

    // Result checker
    always @(posedge i_clk) begin : check_result
        t_dim_res got;
        t_dim_res want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            got = t_dim_res'{res_bus.pin_state, res_bus.busy_res, res_bus.current_level,
                             res_bus.rejected};
            if (pending_status.size() == 0) begin
                log_fail("result item with nothing expected");
            end else begin
                want = pending_status.pop_front();
                if (got.pin !== want.pin || got.busy !== want.busy ||
                    got.level !== want.level || got.rej !== want.rej)
                    log_fail($sformatf({"mismatch: expected pin=%0d busy=%0d level=%0d rej=%0d,",
                                        " got pin=%0d busy=%0d level=%0d rej=%0d"},
                                       want.pin, want.busy, want.level, want.rej,
                                       got.pin, got.busy, got.level, got.rej));
            end
        end
    end

    // Receiver: long hold-off on request, otherwise a rotating stall pattern
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            res_bus.ready <= 1'b0;
            hold_left--;
        end else if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES - 1;
            res_bus.ready <= 1'b0;
        end else begin
            if (pat_age == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pat = 8'hFF;
                    1: stall_pat = 8'($urandom);
                    2: stall_pat = 8'($urandom | $urandom);
                    default: stall_pat = 8'($urandom & $urandom) | 8'h01;
                endcase
                pat_age = $urandom_range(16, 96);
            end
            pat_age--;
            res_bus.ready <= stall_pat[pat_pos];
            pat_pos = pat_pos + 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL pulse_count_backlight_dimmer");
            $finish;
        end
    end

    initial begin
        t_plan_row                  plan[$];
        int                         counted;
        int                         pick;
        logic [pcbd_pkg::OP_W-1:0]  op;
        logic [pcbd_pkg::PCT_W-1:0] pct;

        i_rst_n               = 1'b0;
        cmd_bus.valid         = 1'b0;
        cmd_bus.operation     = pcbd_pkg::OP_TICK;
        cmd_bus.level_percent = '0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = pcbd_pkg::CFG_MAX_LEVEL;
        cfg_bus.data          = '0;
        res_bus.ready         = 1'b0;

        max_reg     = LVL_W'(pcbd_pkg::RESET_MAX_LEVEL);
        half_reg    = TCK_W'(pcbd_pkg::RESET_HALF);
        pin_st      = 1'b0;
        level_st    = LVL_W'(pcbd_pkg::RESET_MAX_LEVEL);
        pulses_st   = '0;
        half_cnt_st = '0;
        low_half_st = 1'b0;

        // Reset values: idle tick, off, equal level, one-pulse step down, busy rejects
        plan.push_back(cmd_row(pcbd_pkg::OP_TICK,      8'd0,   1'b0, 1'b0, 6'd32, 1'b0));
        plan.push_back(cmd_row(pcbd_pkg::OP_POWER_OFF, 8'd0,   1'b0, 1'b0, 6'd32, 1'b0));
        plan.push_back(cmd_row(pcbd_pkg::OP_SET_LEVEL, 8'd255, 1'b1, 1'b0, 6'd32, 1'b0));
        plan.push_back(cmd_row(pcbd_pkg::OP_SET_LEVEL, 8'd97,  1'b1, 1'b1, 6'd31, 1'b0));
        plan.push_back(cmd_row(pcbd_pkg::OP_POWER_ON,  8'd0,   1'b1, 1'b1, 6'd31, 1'b1));
        plan.push_back(cmd_row(pcbd_pkg::OP_POWER_OFF, 8'd0,   1'b1, 1'b1, 6'd31, 1'b1));
        plan.push_back(cmd_row(pcbd_pkg::OP_SET_LEVEL, 8'd0,   1'b1, 1'b1, 6'd31, 1'b1));
        plan.push_back(drain_row());
        // Fastest pulses: zero percent clips to 1, then a rise wraps downward
        plan.push_back(reg_row(pcbd_pkg::CFG_HALF_PERIOD, 16'd1));
        plan.push_back(cmd_row(pcbd_pkg::OP_SET_LEVEL, 8'd0,   1'b1, 1'b1, 6'd1,  1'b0));
        plan.push_back(drain_row());
        plan.push_back(cmd_row(pcbd_pkg::OP_SET_LEVEL, 8'd100, 1'b1, 1'b1, 6'd32, 1'b0));
        plan.push_back(drain_row());
        plan.push_back(cmd_row(pcbd_pkg::OP_POWER_OFF, 8'd0,   1'b0, 1'b0, 6'd32, 1'b0));
        plan.push_back(cmd_row(pcbd_pkg::OP_SET_LEVEL, 8'd101, 1'b1, 1'b0, 6'd32, 1'b0));
        // Max level zero behaves as one; upper data bits are dropped
        plan.push_back(reg_row(pcbd_pkg::CFG_MAX_LEVEL, 16'hFFC0));
        plan.push_back(cmd_row(pcbd_pkg::OP_POWER_ON,  8'd0,   1'b1, 1'b0, 6'd1,  1'b0));
        plan.push_back(cmd_row(pcbd_pkg::OP_SET_LEVEL, 8'd0,   1'b1, 1'b0, 6'd1,  1'b0));
        plan.push_back(cmd_row(pcbd_pkg::OP_SET_LEVEL, 8'd100, 1'b1, 1'b0, 6'd1,  1'b0));
        // Widest level field, half period zero behaves as one
        plan.push_back(reg_row(pcbd_pkg::CFG_MAX_LEVEL, 16'hFFFF));
        plan.push_back(reg_row(pcbd_pkg::CFG_HALF_PERIOD, 16'h0000));
        plan.push_back(cmd_row(pcbd_pkg::OP_SET_LEVEL, 8'd100, 1'b1, 1'b1, 6'd63, 1'b0));
        plan.push_back(drain_row());
        plan.push_back(cmd_row(pcbd_pkg::OP_SET_LEVEL, 8'd1,   1'b1, 1'b1, 6'd1,  1'b0));
        plan.push_back(drain_row());
        plan.push_back(reg_row(CFG_SPARE_2, 16'hA5A5));
        plan.push_back(reg_row(CFG_SPARE_3, 16'h5A5A));
        plan.push_back(cmd_row(pcbd_pkg::OP_TICK,      8'd0,   1'b1, 1'b0, 6'd1,  1'b0));
        // Long half period, single pulse
        plan.push_back(reg_row(pcbd_pkg::CFG_MAX_LEVEL, 16'd32));
        plan.push_back(reg_row(pcbd_pkg::CFG_HALF_PERIOD, 16'd40));
        plan.push_back(cmd_row(pcbd_pkg::OP_POWER_ON,  8'd0,   1'b1, 1'b0, 6'd32, 1'b0));
        plan.push_back(cmd_row(pcbd_pkg::OP_SET_LEVEL, 8'd97,  1'b1, 1'b1, 6'd31, 1'b0));
        plan.push_back(drain_row());
        plan.push_back(cmd_row(pcbd_pkg::OP_TICK,      8'd0,   1'b1, 1'b0, 6'd31, 1'b0));

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_ITEM: begin
                    send_cmd(plan[i].op, plan[i].pct, 1'b1, plan[i].res);
                end
                ROW_CFG: begin
                    write_reg(plan[i].idx, plan[i].data);
                end
                default: begin
                    while (pulses_st != '0)
                        send_cmd(pcbd_pkg::OP_TICK, pcbd_pkg::PCT_W'($urandom), 1'b0, '0);
                end
            endcase
        end

        // Random phases, one register setting each
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    write_reg(pcbd_pkg::CFG_MAX_LEVEL, 16'd32);
                    write_reg(pcbd_pkg::CFG_HALF_PERIOD, 16'd1);
                    hold_asked++;
                end
                1: begin
                    write_reg(pcbd_pkg::CFG_MAX_LEVEL, 16'd1);
                    write_reg(pcbd_pkg::CFG_HALF_PERIOD, 16'd3);
                end
                2: begin
                    write_reg(pcbd_pkg::CFG_MAX_LEVEL, 16'hFF7F);
                    write_reg(pcbd_pkg::CFG_HALF_PERIOD, 16'd2);
                end
                3: begin
                    write_reg(pcbd_pkg::CFG_MAX_LEVEL, 16'd5);
                    write_reg(pcbd_pkg::CFG_HALF_PERIOD, 16'd0);
                end
                4: begin
                    write_reg(pcbd_pkg::CFG_MAX_LEVEL, pcbd_pkg::CFG_DATA_W'($urandom));
                    write_reg(pcbd_pkg::CFG_HALF_PERIOD,
                              pcbd_pkg::CFG_DATA_W'($urandom_range(1, 4)));
                end
                default: begin
                    write_reg(pcbd_pkg::CFG_MAX_LEVEL,
                              pcbd_pkg::CFG_DATA_W'(pcbd_pkg::RESET_MAX_LEVEL));
                    write_reg(pcbd_pkg::CFG_HALF_PERIOD,
                              pcbd_pkg::CFG_DATA_W'(pcbd_pkg::RESET_HALF));
                end
            endcase

            // Mostly commands followed by ticks through the train; some rejected noise
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                pick = $urandom_range(0, 19);
                pct  = pcbd_pkg::PCT_W'($urandom_range(0, 255));
                if (pulses_st != '0) begin
                    op = (pick == 0) ? pcbd_pkg::OP_W'($urandom_range(1, 3))
                                     : pcbd_pkg::OP_TICK;
                    if (op == pcbd_pkg::OP_TICK) counted++;
                end else begin
                    if (pick < 10) begin
                        op = pcbd_pkg::OP_SET_LEVEL;
                        case (pick)
                            0: pct = 8'd0;
                            1: pct = 8'd100;
                            2: pct = pcbd_pkg::PCT_W'($urandom_range(101, 255));
                            3: ;
                            default: pct = pcbd_pkg::PCT_W'($urandom_range(0, 100));
                        endcase
                    end else if (pick < 13) begin
                        op = pcbd_pkg::OP_POWER_ON;
                    end else if (pick < 15) begin
                        op = pcbd_pkg::OP_POWER_OFF;
                    end else begin
                        op = pcbd_pkg::OP_TICK;
                    end
                    if (op != pcbd_pkg::OP_TICK) counted++;
                end
                send_cmd(op, pct, 1'b0, '0);
            end
        end

        // Drain and finish
        stop_cmd();
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (2 * PIPE_CYCLES) @(posedge i_clk);
        if (fails == 0) begin
            $display("PASS pulse_count_backlight_dimmer");
        end else begin
            $display("FAIL pulse_count_backlight_dimmer");
        end
        $finish;
    end

endmodule
